[rtl/gsu_pkg.sv]
// Shared types, constants and escape table for the GSM septet unpacker.
`timescale 1ns / 1ps
`default_nettype none
package gsu_pkg;

  localparam logic [6:0] EscSeptet = 7'd27;

  // skip = ceil((len + 1) * 8 / 7) as (x * SkipRecip) >> SkipShift, x = (len + 1) * 8 + 6
  localparam int SkipRecip = 2341;
  localparam int SkipShift = 14;

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic       msg_active;
    logic [7:0] septet_index;
    logic [7:0] septet_total;
    logic [7:0] skip_septets;
    logic       esc_pending;
    logic [7:0] chars_emitted;
  } gsu_state_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] character;
    logic       has_char;
    logic       last;
    logic [7:0] char_count;
  } gsu_result_t;

  function automatic logic [6:0] esc_map(input logic [6:0] s);
    logic [6:0] c;
    unique case (s)
      7'd10:   c = 7'd12;
      7'd20:   c = 7'd94;   // ^
      7'd40:   c = 7'd123;  // {
      7'd41:   c = 7'd125;  // }
      7'd47:   c = 7'd92;   // backslash
      7'd60:   c = 7'd91;   // [
      7'd61:   c = 7'd126;  // ~
      7'd62:   c = 7'd93;   // ]
      7'd64:   c = 7'd124;  // |
      default: c = 7'd63;   // ?
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/gsu_take.sv]
// One septet step: skip, escape handling, character count and end of message.
`timescale 1ns / 1ps
`default_nettype none
module gsu_take import gsu_pkg::*; (
  input  logic [6:0]  septet,
  input  gsu_state_t  st_in,
  output gsu_state_t  st_out,
  output gsu_result_t res
);

  logic       produced;
  logic [6:0] ch;
  logic [7:0] idx_next;

  always_comb begin
    st_out   = st_in;
    res      = '0;
    produced = 1'b0;
    ch       = '0;
    idx_next = st_in.septet_index + 8'd1;
    if (st_in.msg_active && (st_in.septet_index < st_in.septet_total)) begin
      st_out.septet_index = idx_next;
      if (st_in.septet_index >= st_in.skip_septets) begin
        if (st_in.esc_pending) begin
          st_out.esc_pending = 1'b0;
          produced           = 1'b1;
          ch                 = esc_map(septet);
        end else if (septet == EscSeptet) begin
          st_out.esc_pending = 1'b1;
        end else begin
          produced = 1'b1;
          ch       = septet;
        end
      end
      if (produced) begin
        st_out.chars_emitted = st_in.chars_emitted + 8'd1;
      end
      res.valid     = produced;
      res.has_char  = produced;
      res.character = ch;
      if (idx_next >= st_in.septet_total) begin
        res.valid          = 1'b1;
        res.last           = 1'b1;
        res.char_count     = st_out.chars_emitted;
        st_out.msg_active  = 1'b0;
        st_out.esc_pending = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/gsm_septet_unpacker_core.sv]
// Top level: input register, septet unpacking, and result queue.
// Timing: an accepted octet is held in the input register, unpacked once the result
// queue has room for two results, and its results are written into the result queue.
// Throughput: one octet per cycle while the queue has room; every seventh octet yields
// up to two results; the four-entry queue drains one result per cycle and so sets the rate.
// Reset (rst, synchronous): message idle, all counters and the result queue cleared.
`timescale 1ns / 1ps
`default_nettype none
module gsm_septet_unpacker_core import gsu_pkg::*; #(
  parameter int MAX_SEPTETS = 160
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] octet,
  input  logic       start_req,
  input  logic       with_header,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] character,
  output logic       has_char,
  output logic       last,
  output logic [7:0] char_count
);

  localparam logic [7:0] MaxSeptets = 8'(MAX_SEPTETS);

  logic        stg_valid;
  logic [7:0]  stg_octet;
  logic        stg_start;
  logic        stg_hdr;

  gsu_state_t  st, st_next, st_a, t0_st, t1_st;
  gsu_result_t t0_res, t1_res, r0, r1, w_a;
  logic [7:0]  prev_octet, prev_octet_next;
  logic [2:0]  bit_phase, bit_phase_next, p;
  logic        hdr_pending, hdr_pending_next;

  logic [15:0] pair;
  logic [6:0]  s1;
  logic [8:0]  len_inc;
  logic [11:0] skip_x;
  logic [25:0] skip_prod;
  logic [11:0] skip_full;
  logic [7:0]  clamp_total;

  gsu_result_t      fifo [FifoDepth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  fifo_count, fifo_count_next;
  logic [1:0]       n_push;
  logic             pop, proc_go;

  assign proc_go  = stg_valid && (fifo_count <= CntW'(FifoDepth - 2));
  assign in_ready = !stg_valid || proc_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stg_octet <= octet;
      stg_start <= start_req;
      stg_hdr   <= with_header;
    end
  end

  always_comb begin
    p         = (bit_phase > 3'd6) ? 3'd0 : bit_phase;
    pair      = {stg_octet, prev_octet};
    s1        = 7'(pair >> (4'd8 - {1'b0, p}));
    len_inc   = {1'b0, stg_octet} + 9'd1;
    skip_x    = {len_inc, 3'b000} + 12'd6;
    skip_prod = 26'(skip_x) * 26'(SkipRecip);
    skip_full = skip_prod[SkipShift +: 12];
    st_a      = st;
    if (hdr_pending) begin
      st_a.skip_septets = (skip_full > 12'd255) ? 8'd255 : skip_full[7:0];
    end
    clamp_total = (stg_octet > MaxSeptets) ? MaxSeptets : stg_octet;
  end

  gsu_take u_take0 (
    .septet (s1),
    .st_in  (st_a),
    .st_out (t0_st),
    .res    (t0_res)
  );

  gsu_take u_take1 (
    .septet (stg_octet[7:1]),
    .st_in  (t0_st),
    .st_out (t1_st),
    .res    (t1_res)
  );

  always_comb begin
    st_next          = st;
    prev_octet_next  = prev_octet;
    bit_phase_next   = bit_phase;
    hdr_pending_next = hdr_pending;
    r0               = '0;
    r1               = '0;
    if (proc_go) begin
      if (stg_start) begin
        st_next              = '0;
        prev_octet_next      = '0;
        bit_phase_next       = '0;
        hdr_pending_next     = 1'b0;
        st_next.septet_total = clamp_total;
        if (clamp_total == 8'd0) begin
          r0.valid = 1'b1;
          r0.last  = 1'b1;
        end else begin
          st_next.msg_active = 1'b1;
          hdr_pending_next   = stg_hdr;
        end
      end else if (st.msg_active) begin
        hdr_pending_next = 1'b0;
        r0               = t0_res;
        prev_octet_next  = stg_octet;
        if (p == 3'd6) begin
          st_next        = t1_st;
          r1             = t1_res;
          bit_phase_next = 3'd0;
        end else begin
          st_next        = t0_st;
          bit_phase_next = p + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      prev_octet  <= '0;
      bit_phase   <= '0;
      hdr_pending <= 1'b0;
    end else begin
      st          <= st_next;
      prev_octet  <= prev_octet_next;
      bit_phase   <= bit_phase_next;
      hdr_pending <= hdr_pending_next;
    end
  end

  // result queue
  assign n_push          = {1'b0, r0.valid} + {1'b0, r1.valid};
  assign w_a             = r0.valid ? r0 : r1;
  assign pop             = out_valid && out_ready;
  assign fifo_count_next = fifo_count + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + PtrW'(n_push);
      rd_ptr     <= rd_ptr + PtrW'(pop);
      fifo_count <= fifo_count_next;
    end
    if (n_push != 2'd0) begin
      fifo[wr_ptr] <= w_a;
    end
    if (n_push == 2'd2) begin
      fifo[wr_ptr + PtrW'(1)] <= r1;
    end
  end

  assign out_valid  = (fifo_count != '0);
  assign character  = fifo[rd_ptr].character;
  assign has_char   = fifo[rd_ptr].has_char;
  assign last       = fifo[rd_ptr].last;
  assign char_count = fifo[rd_ptr].char_count;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_idle_no_escape: assert property (@(posedge clk) disable iff (rst)
    !st.msg_active |-> !st.esc_pending)
    else $error("escape pending while idle");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    st.msg_active |-> (st.septet_index < st.septet_total))
    else $error("active message past its septet count");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    bit_phase <= 3'd6)
    else $error("bit phase out of range");

  a_two_push_room: assert property (@(posedge clk) disable iff (rst)
    (n_push == 2'd2) |-> (fifo_count <= CntW'(FifoDepth - 2)))
    else $error("double push without room");

endmodule
`default_nettype wire
